>>> hdl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types and constants for the 1 bpp error-diffusion dither.
// ----------------------------------------------------------------------------
package fsd_pkg;

    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_FRACTION_BITS = 4;

    localparam int PIXEL_W     = 8;
    localparam int THRESH_W    = 8;
    localparam int IMG_W_W     = 11;
    localparam int IMG_H_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd128;
    localparam logic [IMG_W_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [IMG_H_W-1:0]  HEIGHT_RESET = 16'd1;

    // weights are in sixteenths whatever the fraction width
    localparam int WEIGHT_SHIFT = 4;

    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_FIFO_AW    = 2;
    localparam int OUT_FIFO_CW    = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    // position flags handed from the front end to the diffusion stage
    typedef struct packed {
        logic restart;    // row cut short by a width change: drop carries
        logic row_zero;   // first row, line buffer reads as zero
        logic last_x;     // last pixel of the row
        logic has_below;  // a row follows within the image
    } fsd_pos_flags_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_in_row;
        logic       last_in_image;
    } fsd_out_item_t;

endpackage

>>> hdl/fsd_pos.sv
// ----------------------------------------------------------------------------
// fsd_pos
// Raster position tracker: column and row of the next pixel, edge flags.
// ----------------------------------------------------------------------------
module fsd_pos #(
    parameter int MAX_WIDTH = fsd_pkg::DEF_MAX_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [fsd_pkg::IMG_W_W-1:0]         image_width,
    input  logic [fsd_pkg::IMG_H_W-1:0]         image_height,
    input  logic                                advance,
    output logic [$clog2(MAX_WIDTH)-1:0]        x,
    output fsd_pkg::fsd_pos_flags_t             flags
);
    import fsd_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int CW = (XW + 1 > IMG_W_W) ? XW + 1 : IMG_W_W;
    localparam int RW = IMG_H_W + 1;

    logic [XW-1:0]      column_reg, column_next;
    logic [IMG_H_W-1:0] row_reg, row_next;

    logic [CW-1:0]      w_cfg, w_eff, x_inc;
    logic [RW-1:0]      h_eff, row_inc, row_sel, row_cur_inc;
    logic [IMG_H_W-1:0] row_cur;
    logic               restart, last_x, has_below;

    always_comb begin
        w_cfg = CW'(image_width);
        if (w_cfg == '0) begin
            w_eff = CW'(1);
        end else if (w_cfg > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end
        h_eff = (image_height == '0) ? RW'(1) : RW'(image_height);

        // column past a narrowed row: start a new row
        restart = CW'(column_reg) >= w_eff;
        row_inc = RW'(row_reg) + RW'(1);
        row_sel = restart ? row_inc : RW'(row_reg);
        row_cur = (row_sel >= h_eff) ? '0 : row_sel[IMG_H_W-1:0];

        x           = restart ? '0 : column_reg;
        x_inc       = CW'(x) + CW'(1);
        last_x      = x_inc >= w_eff;
        row_cur_inc = RW'(row_cur) + RW'(1);
        has_below   = row_cur_inc < h_eff;

        flags.restart   = restart;
        flags.row_zero  = (row_cur == '0);
        flags.last_x    = last_x;
        flags.has_below = has_below;

        column_next = column_reg;
        row_next    = row_reg;
        if (advance) begin
            if (last_x) begin
                column_next = '0;
                row_next    = has_below ? row_cur_inc[IMG_H_W-1:0] : '0;
            end else begin
                column_next = x_inc[XW-1:0];
                row_next    = row_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

>>> hdl/fsd_line_buffer.sv
// ----------------------------------------------------------------------------
// fsd_line_buffer
// Next-row error store: even and odd column banks, registered read, and
// forwarding of a write that lands on the entry being read.
// ----------------------------------------------------------------------------
module fsd_line_buffer #(
    parameter int MAX_WIDTH = fsd_pkg::DEF_MAX_WIDTH,
    parameter int ERR_W     = fsd_pkg::DEF_FRACTION_BITS + 9
) (
    input  logic                             aclk,
    input  logic                             rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
    output logic signed [ERR_W-1:0]          rd_data,
    input  logic                             wr_a_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]     wr_a_addr,
    input  logic signed [ERR_W-1:0]          wr_a_data,
    input  logic                             wr_b_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]     wr_b_addr,
    input  logic signed [ERR_W-1:0]          wr_b_data
);
    import fsd_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int BD = (MAX_WIDTH + 1) / 2;

    logic signed [ERR_W-1:0] even_mem [0:BD-1];
    logic signed [ERR_W-1:0] odd_mem  [0:BD-1];

    logic signed [ERR_W-1:0] even_q_reg, odd_q_reg, fwd_reg;
    logic                    par_reg, hit_reg;

    logic                    a_even, a_odd, b_even, b_odd;
    logic                    even_we, odd_we, hit_a, hit_b;
    logic [XW-2:0]           even_addr, odd_addr;
    logic signed [ERR_W-1:0] even_wdata, odd_wdata;

    // the two writes of one pixel are on neighbouring columns, so never
    // in the same bank
    always_comb begin
        a_even = wr_a_en && !wr_a_addr[0];
        a_odd  = wr_a_en &&  wr_a_addr[0];
        b_even = wr_b_en && !wr_b_addr[0];
        b_odd  = wr_b_en &&  wr_b_addr[0];

        even_we    = a_even || b_even;
        even_addr  = a_even ? wr_a_addr[XW-1:1] : wr_b_addr[XW-1:1];
        even_wdata = a_even ? wr_a_data : wr_b_data;
        odd_we     = a_odd || b_odd;
        odd_addr   = a_odd ? wr_a_addr[XW-1:1] : wr_b_addr[XW-1:1];
        odd_wdata  = a_odd ? wr_a_data : wr_b_data;

        hit_a = wr_a_en && (wr_a_addr == rd_addr);
        hit_b = wr_b_en && (wr_b_addr == rd_addr);
    end

    always_ff @(posedge aclk) begin
        if (even_we) begin
            even_mem[even_addr] <= even_wdata;
        end
        if (odd_we) begin
            odd_mem[odd_addr] <= odd_wdata;
        end
        if (rd_en) begin
            even_q_reg <= even_mem[rd_addr[XW-1:1]];
            odd_q_reg  <= odd_mem[rd_addr[XW-1:1]];
            par_reg    <= rd_addr[0];
            hit_reg    <= hit_a || hit_b;
            fwd_reg    <= hit_a ? wr_a_data : wr_b_data;
        end
    end

    assign rd_data = hit_reg ? fwd_reg : (par_reg ? odd_q_reg : even_q_reg);

endmodule

>>> hdl/fsd_diffuse.sv
// ----------------------------------------------------------------------------
// fsd_diffuse
// Quantise stage: adds diffused error, thresholds, spreads the new error and
// packs the output bits.
// ----------------------------------------------------------------------------
module fsd_diffuse #(
    parameter int MAX_WIDTH     = fsd_pkg::DEF_MAX_WIDTH,
    parameter int FRACTION_BITS = fsd_pkg::DEF_FRACTION_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [fsd_pkg::THRESH_W-1:0]           threshold,
    input  logic                                   in_valid,
    input  logic [fsd_pkg::PIXEL_W-1:0]            in_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]           in_x,
    input  fsd_pkg::fsd_pos_flags_t                in_flags,
    input  logic signed [FRACTION_BITS+8:0]        rd_data,
    output logic                                   busy,
    output logic                                   wr_a_en,
    output logic [$clog2(MAX_WIDTH)-1:0]           wr_a_addr,
    output logic signed [FRACTION_BITS+8:0]        wr_a_data,
    output logic                                   wr_b_en,
    output logic [$clog2(MAX_WIDTH)-1:0]           wr_b_addr,
    output logic signed [FRACTION_BITS+8:0]        wr_b_data,
    output logic                                   out_push,
    output fsd_pkg::fsd_out_item_t                 out_item
);
    import fsd_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int ERR_W = FRACTION_BITS + 9;
    localparam int W     = FRACTION_BITS + 14;
    localparam int LIMIT = (1 << (FRACTION_BITS + 8)) - 1;
    localparam int WHITE = 255 << FRACTION_BITS;

    localparam logic signed [W-1:0] LIM_POS   = W'(LIMIT);
    localparam logic signed [W-1:0] LIM_NEG   = -W'(LIMIT);
    localparam logic signed [W-1:0] LEVEL_MAX = W'(WHITE);

    function automatic logic signed [ERR_W-1:0] clamp_err(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        if (v > LIM_POS) begin
            r = LIM_POS;
        end else if (v < LIM_NEG) begin
            r = LIM_NEG;
        end else begin
            r = v;
        end
        return ERR_W'(r);
    endfunction

    logic                    s1_valid_reg;
    logic [PIXEL_W-1:0]      s1_pixel_reg;
    logic [XW-1:0]           s1_x_reg;
    fsd_pos_flags_t          s1_flags_reg;

    logic signed [ERR_W-1:0] carry_reg, carry_next;
    logic signed [ERR_W-1:0] pbl_reg, pbl_next;
    logic signed [ERR_W-1:0] pb_reg, pb_next;
    logic [7:0]              bits_reg, bits_next;

    logic signed [ERR_W-1:0] carry_cur, pbl_cur, pb_cur, above, work, pbl_new, pb_new;
    logic [7:0]              bits_cur, bits_new;
    logic signed [W-1:0]     pix_fx, thr_fx, sum, work_w, err;
    logic signed [W-1:0]     p7, p5, p3, sh7, sh5, sh3, sh1;
    logic                    white, emit;

    always_comb begin
        carry_cur = s1_flags_reg.restart ? '0 : carry_reg;
        pbl_cur   = s1_flags_reg.restart ? '0 : pbl_reg;
        pb_cur    = s1_flags_reg.restart ? '0 : pb_reg;
        bits_cur  = s1_flags_reg.restart ? '0 : bits_reg;
        above     = s1_flags_reg.row_zero ? '0 : rd_data;

        pix_fx = $signed(W'({s1_pixel_reg, {FRACTION_BITS{1'b0}}}));
        thr_fx = $signed(W'({threshold, {FRACTION_BITS{1'b0}}}));
        sum    = pix_fx + W'(carry_cur) + W'(above);
        work   = clamp_err(sum);
        work_w = W'(work);
        white  = work_w >= thr_fx;
        err    = work_w - (white ? LEVEL_MAX : W'(0));

        // shares in sixteenths, floor by arithmetic shift
        p7  = (err <<< 3) - err;
        p5  = (err <<< 2) + err;
        p3  = (err <<< 1) + err;
        sh7 = p7 >>> WEIGHT_SHIFT;
        sh5 = p5 >>> WEIGHT_SHIFT;
        sh3 = p3 >>> WEIGHT_SHIFT;
        sh1 = err >>> WEIGHT_SHIFT;

        pbl_new = clamp_err(W'(pb_cur) + sh5);
        pb_new  = s1_flags_reg.last_x ? '0 : clamp_err(sh1);

        bits_new = bits_cur | (white ? 8'h00 : (8'h80 >> s1_x_reg[2:0]));
        emit     = (s1_x_reg[2:0] == 3'd7) || s1_flags_reg.last_x;

        wr_a_en   = s1_valid_reg && s1_flags_reg.has_below && (s1_x_reg != '0);
        wr_a_addr = s1_x_reg - XW'(1);
        wr_a_data = clamp_err(W'(pbl_cur) + sh3);
        wr_b_en   = s1_valid_reg && s1_flags_reg.has_below && s1_flags_reg.last_x;
        wr_b_addr = s1_x_reg;
        wr_b_data = pbl_new;

        out_push               = s1_valid_reg && emit;
        out_item.packed_byte   = bits_new;
        out_item.last_in_row   = s1_flags_reg.last_x;
        out_item.last_in_image = s1_flags_reg.last_x && !s1_flags_reg.has_below;

        carry_next = carry_reg;
        pbl_next   = pbl_reg;
        pb_next    = pb_reg;
        bits_next  = bits_reg;
        if (s1_valid_reg) begin
            carry_next = s1_flags_reg.last_x ? '0 : clamp_err(sh7);
            pbl_next   = s1_flags_reg.has_below ? pbl_new : pbl_cur;
            pb_next    = s1_flags_reg.has_below ? pb_new : pb_cur;
            bits_next  = emit ? 8'h00 : bits_new;
            if (s1_flags_reg.last_x) begin
                pbl_next = '0;
                pb_next  = '0;
            end
        end
    end

    assign busy = s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            carry_reg    <= '0;
            pbl_reg      <= '0;
            pb_reg       <= '0;
            bits_reg     <= '0;
        end else begin
            s1_valid_reg <= in_valid;
            carry_reg    <= carry_next;
            pbl_reg      <= pbl_next;
            pb_reg       <= pb_next;
            bits_reg     <= bits_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            s1_pixel_reg <= in_pixel;
            s1_x_reg     <= in_x;
            s1_flags_reg <= in_flags;
        end
    end

endmodule

>>> hdl/fsd_out_fifo.sv
// ----------------------------------------------------------------------------
// fsd_out_fifo
// Small result queue between the quantise stage and the output channel.
// ----------------------------------------------------------------------------
module fsd_out_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  fsd_pkg::fsd_out_item_t            push_item,
    input  logic                              pop,
    output logic                              not_empty,
    output fsd_pkg::fsd_out_item_t            head_item,
    output logic [fsd_pkg::OUT_FIFO_CW-1:0]   count
);
    import fsd_pkg::*;

    fsd_out_item_t             slot_reg [0:OUT_FIFO_DEPTH-1];
    logic [OUT_FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [OUT_FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [OUT_FIFO_CW-1:0]    count_reg, count_next;
    logic                      do_pop;

    always_comb begin
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = push   ? wr_ptr_reg + OUT_FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + OUT_FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + OUT_FIFO_CW'(push) - OUT_FIFO_CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

>>> hdl/floyd_steinberg_dither_1bpp.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_dither_1bpp
// 8-bit grey to 1 bpp error-diffusion dither, bytes packed MSB first.
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    s_tdata[7:0] pixel
//   m_       out  m_tvalid/m_tready    m_tdata[7:0] packed_byte, m_tlast
//                                      last_in_row, m_tuser last_in_image
//   cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// One pixel per clock while s_tready is high. A pixel is quantised in the
// cycle after acceptance, once the line buffer read returns; the error carry
// to the right is the registered loop that sets the rate. A byte is raised on
// m_tvalid once the pixel that completes it has passed the quantise stage
// register and been written into the result queue. A four-entry result
// queue lets pixels keep flowing while m_tready is low until it fills.
// Reset is synchronous; the line buffer holds no reset contents.
// ----------------------------------------------------------------------------
module floyd_steinberg_dither_1bpp #(
    parameter int MAX_WIDTH     = fsd_pkg::DEF_MAX_WIDTH,
    parameter int FRACTION_BITS = fsd_pkg::DEF_FRACTION_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] pixel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] packed_byte
    output logic                                m_tlast,
    output logic                                m_tuser,   // [0] last_in_image
    input  logic                                cfg_we,
    input  logic [fsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fsd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import fsd_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int ERR_W = FRACTION_BITS + 9;

    logic [THRESH_W-1:0] threshold_reg;
    logic [IMG_W_W-1:0]  image_width_reg;
    logic [IMG_H_W-1:0]  image_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESH_RESET;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD:    threshold_reg    <= cfg_wdata[THRESH_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    logic                    s_fire, busy, out_push, m_fire;
    logic [XW-1:0]           pos_x, wr_a_addr, wr_b_addr;
    fsd_pos_flags_t          pos_flags;
    logic signed [ERR_W-1:0] rd_data, wr_a_data, wr_b_data;
    logic                    wr_a_en, wr_b_en;
    fsd_out_item_t           out_item, head_item;
    logic [OUT_FIFO_CW-1:0]  fifo_count;

    // room for every transaction already in flight plus this one
    assign s_tready = (fifo_count + OUT_FIFO_CW'(busy)) < OUT_FIFO_CW'(OUT_FIFO_DEPTH);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    fsd_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .advance      (s_fire),
        .x            (pos_x),
        .flags        (pos_flags)
    );

    fsd_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH),
        .ERR_W     (ERR_W)
    ) u_line_buffer (
        .aclk      (aclk),
        .rd_en     (s_fire),
        .rd_addr   (pos_x),
        .rd_data   (rd_data),
        .wr_a_en   (wr_a_en),
        .wr_a_addr (wr_a_addr),
        .wr_a_data (wr_a_data),
        .wr_b_en   (wr_b_en),
        .wr_b_addr (wr_b_addr),
        .wr_b_data (wr_b_data)
    );

    fsd_diffuse #(
        .MAX_WIDTH     (MAX_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_diffuse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .threshold (threshold_reg),
        .in_valid  (s_fire),
        .in_pixel  (s_tdata),
        .in_x      (pos_x),
        .in_flags  (pos_flags),
        .rd_data   (rd_data),
        .busy      (busy),
        .wr_a_en   (wr_a_en),
        .wr_a_addr (wr_a_addr),
        .wr_a_data (wr_a_data),
        .wr_b_en   (wr_b_en),
        .wr_b_addr (wr_b_addr),
        .wr_b_data (wr_b_data),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    fsd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (out_push),
        .push_item (out_item),
        .pop       (m_fire),
        .not_empty (m_tvalid),
        .head_item (head_item),
        .count     (fifo_count)
    );

    assign m_tdata = head_item.packed_byte;
    assign m_tlast = head_item.last_in_row;
    assign m_tuser = head_item.last_in_image;

endmodule

>>> hdl/fsd_checker.sv
// ----------------------------------------------------------------------------
// fsd_checker
// Port-level checks on the dither's channels, bound to the top level.
// ----------------------------------------------------------------------------
module fsd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // the end of an image is always the end of a row
    a_image_end_is_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("last_in_image without last_in_row");

    // leaving reset: nothing pending, ready for a pixel
    a_reset_state: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_tvalid && s_tready)
        else $error("not idle after reset");

    // a result shows up only after the pixel that closes it has been accepted
    a_out_follows_in: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without an accepted pixel");

endmodule

bind floyd_steinberg_dither_1bpp fsd_checker u_fsd_checker (.*);
